FILE: src/ffpa_pkg.sv
// Shared types and constants for the first-fit pool allocator.
// Used by ffpa_ctrl, ffpa_dp and first_fit_pool_allocator; depends on nothing.
package ffpa_pkg;

	// Descriptor table geometry
	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	// Minimum block granule, as log2 of the byte count
	localparam int BASE_ALIGN_LOG2 = 6;

	// Pool size after reset
	localparam logic [31:0] POOL_RESET_BYTES = 32'h0400_0000;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_RESET = 2'd2,
		OP_STATS = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIZE  = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_WALK,
		S_CARVE,
		S_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;
		logic prep;
		logic walk;
		logic carve;
		logic load_out;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		op_t  op;
		logic arg_bad;
		logic hit;
		logic walk_end;
	} sts_t;

endpackage

FILE: src/first_fit_pool_allocator.sv
// First-fit pool allocator, top level: joins controller and datapath and
// exposes the request, result and configuration channels. Depends on ffpa_pkg.
//
// Allocates, frees and recycles blocks of a byte pool given by pool_bytes
// (reset 64 MiB), with offsets relative to the pool base. Every request beat
// gives exactly one result beat carrying status and the pool statistics.
// One request is in flight at a time. Reset-all, stats and an allocate with a
// zero or overflowing size skip the walk and load their result after prepare.
// Allocate and free walk the descriptor table newest entry first, one entry
// per cycle through the registered read of the descriptor memory. A free, or
// an allocate that finds no idle fit, walks every recorded block; an allocate
// that then carves a new block goes through the carve state before its result
// is loaded. A hit ends the walk early. The next request is accepted in the
// cycle after the result is loaded, while that result may still wait on the
// output. Write pool_bytes only while no request is in flight.
module first_fit_pool_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [31:0]                cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic [31:0]                request_bytes,
	input  logic [4:0]                 align_log2,
	input  logic [31:0]                block_offset,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [31:0]                result_offset,
	output logic [31:0]                used_bytes,
	output logic [31:0]                free_bytes,
	output logic [ffpa_pkg::CNT_W-1:0] block_count,
	output logic [ffpa_pkg::CNT_W-1:0] idle_block_count
);
	import ffpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffpa_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.request_bytes    (request_bytes),
		.align_log2       (align_log2),
		.block_offset     (block_offset),
		.status           (status),
		.result_offset    (result_offset),
		.used_bytes       (used_bytes),
		.free_bytes       (free_bytes),
		.block_count      (block_count),
		.idle_block_count (idle_block_count)
	);

endmodule

FILE: src/ffpa_ctrl.sv
// Controller state machine for the first-fit pool allocator.
// Depends on ffpa_pkg; drives ffpa_dp through cmd_t and reads sts_t.
module ffpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ffpa_pkg::sts_t  sts,
	output ffpa_pkg::cmd_t  cmd
);
	import ffpa_pkg::*;

	state_t state_q, state_d;
	logic   out_vld_q;
	logic   out_free;

	assign out_valid = out_vld_q;
	assign out_free  = !out_vld_q || out_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				case (sts.op)
					OP_ALLOC: state_d = sts.arg_bad ? S_DONE : S_WALK;
					OP_FREE:  state_d = S_WALK;
					default:  state_d = S_DONE;
				endcase
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.hit) begin
					state_d = S_DONE;
				end else if (sts.walk_end) begin
					state_d = (sts.op == OP_ALLOC) ? S_CARVE : S_DONE;
				end
			end
			S_CARVE: begin
				cmd.carve = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output beat valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Walk only runs for allocate or free
	a_walk_op: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> (sts.op == OP_ALLOC || sts.op == OP_FREE))
		else $error("walk entered for an operation without a search");

	// Carve only follows a walk that missed
	a_carve_prev: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CARVE |-> $past(state_q) == S_WALK && $past(sts.walk_end)
			&& !$past(sts.hit))
		else $error("carve without a missed walk");

	// A finished result never overwrites one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result loaded over a pending beat");

endmodule

FILE: src/ffpa_dp.sv
// Datapath for the first-fit pool allocator: descriptor memories, busy bits,
// bump pointer, size rounding, search walk and the output register.
// Depends on ffpa_pkg; steered by ffpa_ctrl through cmd_t.
module ffpa_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ffpa_pkg::cmd_t            cmd,
	output ffpa_pkg::sts_t            sts,
	input  logic                      cfg_we,
	input  logic [31:0]               cfg_data,
	input  logic [1:0]                operation,
	input  logic [31:0]               request_bytes,
	input  logic [4:0]                align_log2,
	input  logic [31:0]               block_offset,
	output logic [2:0]                status,
	output logic [31:0]               result_offset,
	output logic [31:0]               used_bytes,
	output logic [31:0]               free_bytes,
	output logic [ffpa_pkg::CNT_W-1:0] block_count,
	output logic [ffpa_pkg::CNT_W-1:0] idle_block_count
);
	import ffpa_pkg::*;

	// Descriptor memories
	logic [31:0] mem_off [MAX_BLOCKS];
	logic [31:0] mem_size [MAX_BLOCKS];

	// Architectural state
	logic [31:0]           pool_q;
	logic [31:0]           bump_q;
	logic [CNT_W-1:0]      eu_q;
	logic [CNT_W-1:0]      idle_q;
	logic [MAX_BLOCKS-1:0] busy_q;

	// Latched request
	op_t         op_q;
	logic [31:0] req_q;
	logic [4:0]  alog_q;
	logic [31:0] boff_q;
	logic [31:0] sz_q;
	status_t     st_q;
	logic [31:0] res_off_q;

	// Walk state
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_dec;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [31:0]      rd_off_s1;
	logic [31:0]      rd_size_s1;

	// Rounding
	logic [31:0] align_mask;
	logic [32:0] sz_sum;
	logic [32:0] sz_round;
	logic        arg_bad;

	// Carve checks
	logic [32:0]      bump_next;
	logic             exhausted;
	logic             table_full;
	logic [IDX_W-1:0] wr_addr;

	logic             hit;
	logic             walk_end;
	logic             hit_busy;

	// Round up to the larger of the requested alignment and the base granule
	always_comb begin
		if (alog_q < 5'(BASE_ALIGN_LOG2)) begin
			align_mask = (32'd1 << BASE_ALIGN_LOG2) - 32'd1;
		end else begin
			align_mask = (32'd1 << alog_q) - 32'd1;
		end
		sz_sum   = {1'b0, req_q} + {1'b0, align_mask};
		sz_round = sz_sum & ~{1'b0, align_mask};
		arg_bad  = (req_q == 32'd0) || sz_round[32];
	end

	// Compare the entry read last cycle
	assign hit_busy = busy_q[rd_idx_s1];
	always_comb begin
		if (op_q == OP_ALLOC) begin
			hit = rd_vld_s1 && !hit_busy && (rd_size_s1 >= sz_q);
		end else begin
			hit = rd_vld_s1 && (rd_off_s1 == boff_q);
		end
	end
	assign walk_end = (idx_q == '0) && !rd_vld_s1;

	// Next read address, newest entry first
	assign idx_dec = idx_q - CNT_W'(1);
	assign rd_addr = idx_dec[IDX_W-1:0];
	assign rd_en   = cmd.walk && (idx_q != '0) && !hit;

	assign bump_next  = {1'b0, bump_q} + {1'b0, sz_q};
	assign exhausted  = bump_next > {1'b0, pool_q};
	assign table_full = eu_q >= CNT_W'(MAX_BLOCKS);
	assign wr_addr    = eu_q[IDX_W-1:0];

	assign sts.op       = op_q;
	assign sts.arg_bad  = arg_bad;
	assign sts.hit      = hit;
	assign sts.walk_end = walk_end;

	// Descriptor memory write on carve
	always_ff @(posedge clk) begin
		if (cmd.carve && !exhausted && !table_full) begin
			mem_off[wr_addr]  <= bump_q;
			mem_size[wr_addr] <= sz_q;
		end
	end

	// Descriptor memory registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_off_s1  <= mem_off[rd_addr];
			rd_size_s1 <= mem_size[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	// Latch the request beat
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op_t'(operation);
			req_q  <= request_bytes;
			alog_q <= align_log2;
			boff_q <= block_offset;
		end
		if (cmd.prep) begin
			sz_q <= sz_round[31:0];
		end
	end

	// Control state: pool size, bump pointer, counts, busy bits, walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q    <= POOL_RESET_BYTES;
			bump_q    <= '0;
			eu_q      <= '0;
			idle_q    <= '0;
			busy_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			st_q      <= ST_OK;
			res_off_q <= '0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_data;
			end
			// Set up the operation
			if (cmd.prep) begin
				idx_q     <= eu_q;
				rd_vld_s1 <= 1'b0;
				res_off_q <= '0;
				st_q      <= (op_q == OP_ALLOC && arg_bad) ? ST_BAD_SIZE : ST_OK;
				if (op_q == OP_RESET) begin
					busy_q <= '0;
					idle_q <= eu_q;
				end
			end
			// Advance the walk and apply a hit
			if (cmd.walk) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					idx_q <= idx_dec;
				end
				if (hit) begin
					if (op_q == OP_ALLOC) begin
						busy_q[rd_idx_s1] <= 1'b1;
						idle_q            <= idle_q - CNT_W'(1);
						res_off_q         <= rd_off_s1;
					end else begin
						busy_q[rd_idx_s1] <= 1'b0;
						if (hit_busy) begin
							idle_q <= idle_q + CNT_W'(1);
						end
					end
				end else if (walk_end && op_q == OP_FREE) begin
					st_q <= ST_NOT_FOUND;
				end
			end
			// Carve a new block at the bump pointer
			if (cmd.carve) begin
				if (exhausted) begin
					st_q <= ST_EXHAUSTED;
				end else if (table_full) begin
					st_q <= ST_FULL;
				end else begin
					busy_q[wr_addr] <= 1'b1;
					eu_q            <= eu_q + CNT_W'(1);
					bump_q          <= bump_next[31:0];
					res_off_q       <= bump_q;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status           <= st_q;
			result_offset    <= res_off_q;
			used_bytes       <= bump_q;
			free_bytes       <= (pool_q >= bump_q) ? (pool_q - bump_q) : 32'd0;
			block_count      <= eu_q;
			idle_block_count <= idle_q;
		end
	end

	// Idle blocks are a subset of recorded blocks
	a_idle_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		idle_q <= eu_q)
		else $error("idle count exceeds recorded blocks");

	// Entries past the recorded count are never busy
	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q >> eu_q) == '0)
		else $error("busy bit set beyond recorded blocks");

	// Bump pointer only moves on a carve, and only upward
	a_bump_mono: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q != $past(bump_q) |-> $past(cmd.carve) && bump_q > $past(bump_q))
		else $error("bump pointer moved outside a carve");

endmodule

FILE: dv/tb_first_fit_pool_allocator.sv
// Self-checking testbench for first_fit_pool_allocator: directed and random requests,
// each result beat checked against a cycle-free predictor of the descriptor table.
// Depends on ffpa_pkg and the RTL under src/.
module tb_first_fit_pool_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import ffpa_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 80;

	// Result beat as six zero-extended fields:
	// status, offset, used, free, block count, idle count
	typedef logic [5:0][31:0] pool_result_t;

	// Predictor of the allocator plus the queue of results it owes
	class pool_tracker;
		logic [31:0]  pool_limit;
		logic [31:0]  entry_ofs [MAX_BLOCKS];
		logic [31:0]  entry_len [MAX_BLOCKS];
		bit           entry_busy [MAX_BLOCKS];
		int           n_entries;
		logic [31:0]  bump_ptr;
		pool_result_t pending_results [$];
		int           mismatches;

		function new();
			pool_limit = POOL_RESET_BYTES;
			n_entries = 0;
			bump_ptr = '0;
			mismatches = 0;
			foreach (entry_busy[k]) begin
				entry_busy[k] = 1'b0;
			end
		endfunction

		// Apply one accepted request and queue the result it must produce
		function void predict_request(op_t op, logic [31:0] req, logic [4:0] alog2,
				logic [31:0] boff);
			status_t      st;
			logic [31:0]  grant;
			logic [63:0]  gran;
			logic [63:0]  sz;
			int           hit;
			int           idle;
			pool_result_t r;
			st = ST_OK;
			grant = '0;
			hit = -1;
			case (op)
				OP_ALLOC: begin
					// round to the requested alignment, then to the base granule
					gran = 64'd1 << alog2;
					sz = (64'(req) + gran - 64'd1) & ~(gran - 64'd1);
					gran = 64'd1 << BASE_ALIGN_LOG2;
					sz = (sz + gran - 64'd1) & ~(gran - 64'd1);
					if (req == '0 || sz > 64'hFFFF_FFFF) begin
						st = ST_BAD_SIZE;
					end else begin
						for (int k = n_entries - 1; k >= 0; k--) begin
							if (hit < 0 && !entry_busy[k] && 64'(entry_len[k]) >= sz)
								hit = k;
						end
						if (hit >= 0) begin
							entry_busy[hit] = 1'b1;
							grant = entry_ofs[hit];
						end else if (64'(bump_ptr) + sz > 64'(pool_limit)) begin
							st = ST_EXHAUSTED;
						end else if (n_entries >= MAX_BLOCKS) begin
							st = ST_FULL;
						end else begin
							entry_ofs[n_entries] = bump_ptr;
							entry_len[n_entries] = sz[31:0];
							entry_busy[n_entries] = 1'b1;
							n_entries++;
							grant = bump_ptr;
							bump_ptr = bump_ptr + sz[31:0];
						end
					end
				end
				OP_FREE: begin
					for (int k = n_entries - 1; k >= 0; k--) begin
						if (hit < 0 && entry_ofs[k] == boff)
							hit = k;
					end
					if (hit >= 0)
						entry_busy[hit] = 1'b0;
					else
						st = ST_NOT_FOUND;
				end
				OP_RESET: begin
					for (int k = 0; k < n_entries; k++) begin
						entry_busy[k] = 1'b0;
					end
				end
				default: ;
			endcase
			idle = 0;
			for (int k = 0; k < n_entries; k++) begin
				if (!entry_busy[k])
					idle++;
			end
			r[0] = 32'(st);
			r[1] = grant;
			r[2] = bump_ptr;
			r[3] = (pool_limit >= bump_ptr) ? pool_limit - bump_ptr : '0;
			r[4] = 32'(n_entries & 127);
			r[5] = 32'(idle & 127);
			pending_results.push_back(r);
		endfunction

		// Compare one result beat with the oldest queued result
		function void check_result(logic [2:0] st, logic [31:0] ofs, logic [31:0] used,
				logic [31:0] free, logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] idle);
			string        field_name [6] = '{"status", "result_offset", "used_bytes",
				"free_bytes", "block_count", "idle_block_count"};
			pool_result_t got;
			pool_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with none outstanding, status %0d", $time, st);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			got[0] = 32'(st);
			got[1] = ofs;
			got[2] = used;
			got[3] = free;
			got[4] = 32'(cnt);
			got[5] = 32'(idle);
			for (int f = 0; f < 6; f++) begin
				if (got[f] !== want[f]) begin
					$display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
						$time, field_name[f], want[f], got[f]);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [31:0]       cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        operation;
	logic [31:0]       request_bytes;
	logic [4:0]        align_log2;
	logic [31:0]       block_offset;
	logic              out_valid;
	logic              out_ready;
	logic [2:0]        status;
	logic [31:0]       result_offset;
	logic [31:0]       used_bytes;
	logic [31:0]       free_bytes;
	logic [CNT_W-1:0]  block_count;
	logic [CNT_W-1:0]  idle_block_count;

	pool_tracker tracker = new();
	int          send_idle_pct;
	int          stall_pct;
	bit          hold_req;
	int          quiet_cycles;

	first_fit_pool_allocator i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.request_bytes    (request_bytes),
		.align_log2       (align_log2),
		.block_offset     (block_offset),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.result_offset    (result_offset),
		.used_bytes       (used_bytes),
		.free_bytes       (free_bytes),
		.block_count      (block_count),
		.idle_block_count (idle_block_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Observe every beat at the rising edge; track cycles with no beat at all
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.pool_limit = cfg_data;
			if (in_valid && in_ready)
				tracker.predict_request(op_t'(operation), request_bytes, align_log2,
					block_offset);
			if (out_valid && out_ready)
				tracker.check_result(status, result_offset, used_bytes, free_bytes,
					block_count, idle_block_count);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// End the run if the block stops moving beats
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("Regression FAIL");
		$finish;
	end

	// Drive out_ready: random stalls, or a long hold-off when requested
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one request beat and hold it until accepted; entered and left at a falling edge
	task automatic send_request(op_t op, logic [31:0] req, logic [4:0] alog2,
			logic [31:0] boff);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_bytes <= req;
		align_log2 <= alog2;
		block_offset <= boff;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid and hold until every owed result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Write pool_bytes while the block is idle
	task automatic write_pool_size(logic [31:0] bytes);
		cfg_valid <= 1'b1;
		cfg_data <= bytes;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Build one random request: mostly small allocations and frees of live offsets
	task automatic send_random_request();
		int          pick;
		op_t         op;
		logic [31:0] req;
		logic [4:0]  alog2;
		logic [31:0] boff;
		pick = $urandom_range(99);
		op = (pick < 45) ? OP_ALLOC : (pick < 80) ? OP_FREE : (pick < 88) ? OP_RESET : OP_STATS;
		req = $urandom;
		boff = $urandom;
		alog2 = 5'($urandom_range(31));
		if (op == OP_ALLOC) begin
			pick = $urandom_range(99);
			if (pick < 55)
				req = $urandom_range(256, 1);
			else if (pick < 75)
				req = $urandom_range(8192, 257);
			else if (pick < 85)
				req = $urandom_range(1 << 20, 8193);
			else if (pick >= 95)
				case ($urandom_range(5))
					0: req = '0;
					1: req = 32'd1;
					2: req = 32'd64;
					3: req = 32'd65;
					4: req = 32'hFFFF_FFC0;
					default: req = 32'hFFFF_FFFF;
				endcase
			pick = $urandom_range(99);
			if (pick < 65)
				alog2 = 5'(BASE_ALIGN_LOG2);
			else if (pick < 90)
				alog2 = 5'($urandom_range(16));
		end else if (op == OP_FREE) begin
			pick = $urandom_range(99);
			if (pick < 75 && tracker.n_entries > 0)
				boff = tracker.entry_ofs[$urandom_range(tracker.n_entries - 1)];
			else if (pick < 85)
				boff = 32'($urandom_range(255)) << BASE_ALIGN_LOG2;
		end
		send_request(op, req, alog2, boff);
	endtask

	task automatic run_phase(int items, int idle_pct, int stall);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		repeat (items) send_random_request();
	endtask

	initial begin
		logic [32:0] room;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_STATS;
		request_bytes = '0;
		align_log2 = '0;
		block_offset = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: size errors, carving to the exact pool end, reuse, frees, reset
		write_pool_size(32'd4096);
		send_request(OP_STATS, $urandom, 5'd31, $urandom);
		send_request(OP_ALLOC, 32'd0, 5'd6, $urandom);
		send_request(OP_ALLOC, 32'hFFFF_FFFF, 5'd6, $urandom);
		send_request(OP_ALLOC, 32'h8000_0001, 5'd31, $urandom);
		send_request(OP_ALLOC, 32'd1, 5'd0, $urandom);
		send_request(OP_ALLOC, 32'd100, 5'd7, $urandom);
		send_request(OP_ALLOC, 32'd1, 5'd16, $urandom);
		send_request(OP_ALLOC, 32'd4000, 5'd6, $urandom);
		send_request(OP_ALLOC, 32'd3904, 5'd6, $urandom);
		send_request(OP_FREE, $urandom, 5'd6, 32'd64);
		send_request(OP_FREE, $urandom, 5'd6, 32'd64);
		send_request(OP_FREE, $urandom, 5'd6, 32'h0001_2345);
		send_request(OP_FREE, $urandom, 5'd6, 32'hFFFF_FFFF);
		send_request(OP_ALLOC, 32'd64, 5'd6, $urandom);
		send_request(OP_ALLOC, 32'd65, 5'd0, $urandom);
		send_request(OP_RESET, $urandom, 5'd31, $urandom);
		send_request(OP_ALLOC, 32'd64, 5'd6, $urandom);
		send_request(OP_ALLOC, 32'd2, 5'd31, $urandom);
		send_request(OP_ALLOC, 32'd1, 5'd17, $urandom);
		send_request(OP_ALLOC, 32'h7FFF_FFFF, 5'd6, $urandom);
		send_request(OP_FREE, $urandom, 5'd6, 32'd0);
		send_request(OP_STATS, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
		wait_drained();

		// Largest pool, no idling
		write_pool_size(32'hFFFF_FFFF);
		run_phase(100, 0, 0);
		wait_drained();

		// Pool just above usage, sender idling
		room = {1'b0, tracker.bump_ptr} + 33'h0_0001_0000;
		write_pool_size(room[32] ? 32'hFFFF_FFFF : room[31:0]);
		run_phase(80, 60, 0);
		wait_drained();

		// Empty pool, below usage, receiver stalling
		write_pool_size(32'd0);
		run_phase(80, 0, 60);
		wait_drained();

		// Largest pool again, both sides idling, with a full drain midway
		write_pool_size(32'hFFFF_FFFF);
		run_phase(50, 24, 24);
		wait_drained();
		run_phase(50, 24, 24);
		wait_drained();

		// Reset-size pool; long receiver hold-off while requests keep coming
		write_pool_size(POOL_RESET_BYTES);
		run_phase(10, 0, 0);
		hold_req = 1'b1;
		run_phase(70, 0, 0);
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: first_fit_pool_allocator.f
src/ffpa_pkg.sv
src/ffpa_ctrl.sv
src/ffpa_dp.sv
src/first_fit_pool_allocator.sv
dv/tb_first_fit_pool_allocator.sv
